@@ design/cvl_pkg.sv @@
// Shared types and constants for the cell visibility lookup block.
`default_nettype none

package cvl_pkg;

    // Sizes of the two stores
    localparam int MAX_REGIONS = 256;
    localparam int MAX_GRID    = 1024;
    localparam int VIS_DEPTH   = 65536;
    localparam int REG_AW      = $clog2(MAX_REGIONS);
    localparam int REG_CW      = REG_AW + 1;
    localparam int VIS_AW      = $clog2(VIS_DEPTH);
    localparam int PROD_W      = 2 * REG_AW + 1;
    localparam int FLAT_W      = PROD_W + 1;

    // Field widths
    localparam int COORD_W = 11;
    localparam int CELL_W  = 12;
    localparam int CNT_W   = 9;

    // Item kinds carried in s_tuser
    typedef enum logic [1:0] {
        OP_QUERY        = 2'd0,
        OP_REGION_WRITE = 2'd1,
        OP_VIS_WRITE    = 2'd2
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_GRID_WIDTH   = 2'd0,
        CFG_GRID_HEIGHT  = 2'd1,
        CFG_REGION_COUNT = 2'd2
    } cfg_index_t;

    // One region table entry
    typedef struct packed {
        logic               solid;
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } region_entry_t;

    // Access command for the visibility store
    typedef struct packed {
        logic              wr_en;
        logic [VIS_AW-1:0] wr_addr;
        logic              wr_data;
        logic [VIS_AW-1:0] rd_addr;
    } vis_cmd_t;

endpackage

`default_nettype wire

@@ design/cvl_vis_store.sv @@
// Visibility bit store with a clearing pass after reset.
`default_nettype none

module cvl_vis_store (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire cvl_pkg::vis_cmd_t cmd,
    output logic                 rd_data,
    output logic                 clear_done
);

    logic                     vis_mem [cvl_pkg::VIS_DEPTH];
    logic [cvl_pkg::VIS_AW:0] clr_cnt_reg;
    logic                     rd_data_reg;

    assign clear_done = clr_cnt_reg[cvl_pkg::VIS_AW];
    assign rd_data    = rd_data_reg;

    // Advance the clearing pointer until every bit has been zeroed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (!clear_done) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Clear or write one bit, read one bit a cycle
    always_ff @(posedge aclk) begin
        if (!clear_done) begin
            vis_mem[clr_cnt_reg[cvl_pkg::VIS_AW-1:0]] <= 1'b0;
        end else if (cmd.wr_en) begin
            vis_mem[cmd.wr_addr] <= cmd.wr_data;
        end
        rd_data_reg <= vis_mem[cmd.rd_addr];
    end

endmodule

`default_nettype wire

@@ design/cell_visibility_lookup_unit.sv @@
// Top level of the cell visibility lookup: region scan and visibility query.
//
// Input channel s_*: one item per transfer, kind in s_tuser (0 query,
// 1 region write, 2 visibility bit write, 3 dropped). Writes are taken in
// the idle state and give no result. A query gives one result on m_*.
// One region table read per cycle serves the observer and the target cell
// together over at most n entries, n being the saturated region count, and
// the scan stops early once both cells are resolved. Then the matrix index
// is formed (one multiply), one visibility bit is read and the result is
// loaded into the output register. Items are handled one at a time; a
// query holds the input until its result is loaded, and the next item is
// taken while a finished result still waits on m_*.
// After reset the visibility store is cleared, one bit per cycle; no item
// is taken during that pass, configuration writes are.
// Registers reset to grid 64 x 64 and region count 0. The region table is
// not initialised. When m_tready is low the result holds in the output
// register, and a following query waits at its end until the slot frees.
// Config writes (cfg_*) are always taken and must be made while idle.
`default_nettype none

module cell_visibility_lookup_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [10:0]  cfg_data,
    // Input items
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // table_address[15:0], region_x[26:16], region_y[37:27], region_w[48:38],
    // region_h[59:49], region_solid[60], vis_bit[61], obs_col[73:62],
    // obs_row[85:74], tgt_col[97:86], tgt_row[109:98], zero[111:110]
    input  wire logic [111:0] s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]   s_tuser,
    // Results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // visible[0], observer_found[1], target_found[2], observer_region[10:3],
    // target_region[18:11], zero[23:19]
    output logic [23:0]       m_tdata
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_MUL   = 5'b00100,
        S_VREAD = 5'b01000,
        S_VRES  = 5'b10000
    } state_t;

    localparam int CW = cvl_pkg::COORD_W;

    state_t state_reg, state_next;

    // Configuration
    logic [CW-1:0]             grid_w_reg, grid_h_reg;
    logic [cvl_pkg::CNT_W-1:0] region_count_reg;
    logic [CW-1:0]             grid_w_eff, grid_h_eff;
    logic [cvl_pkg::CNT_W-1:0] n_eff;

    // Input unpacking
    cvl_pkg::opcode_t         in_op;
    logic [15:0]              in_addr;
    cvl_pkg::region_entry_t   in_entry;
    logic                     in_vis_bit;
    logic [cvl_pkg::CELL_W-1:0] in_ox, in_oy, in_tx, in_ty;
    logic                     s_accept;

    // Region table
    cvl_pkg::region_entry_t   region_mem [cvl_pkg::MAX_REGIONS];
    cvl_pkg::region_entry_t   region_rd_reg;
    logic [cvl_pkg::REG_AW-1:0] reg_rd_addr;
    logic                     reg_we;

    // Query working registers
    logic [CW-1:0]              obs_x_reg, obs_y_reg, tgt_x_reg, tgt_y_reg;
    logic                       obs_in_reg, tgt_in_reg;
    logic                       obs_found_reg, tgt_found_reg;
    logic                       obs_solid_reg, tgt_solid_reg;
    logic [cvl_pkg::REG_AW-1:0] obs_idx_reg, tgt_idx_reg;
    logic [cvl_pkg::REG_CW-1:0] cmp_idx_reg;
    logic [cvl_pkg::PROD_W-1:0] prod_reg;
    logic [cvl_pkg::VIS_AW-1:0] vis_addr_reg;
    logic                       vis_ok_reg;
    logic                       obs_done, tgt_done, scan_end;
    logic                       obs_hit, tgt_hit;
    logic [cvl_pkg::FLAT_W-1:0] flat;

    // Visibility store
    cvl_pkg::vis_cmd_t vis_cmd;
    logic              vis_rd_data;
    logic              clear_done;

    // Output register
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic        out_load;

    function automatic logic cell_in_grid(input logic [cvl_pkg::CELL_W-1:0] c,
                                          input logic [CW-1:0] lim);
        return !c[cvl_pkg::CELL_W-1] && (c[CW-1:0] < lim);
    endfunction

    function automatic logic cell_in_region(input logic [CW-1:0] cx,
                                            input logic [CW-1:0] cy,
                                            input cvl_pkg::region_entry_t e);
        logic [CW:0] x_end;
        logic [CW:0] y_end;
        x_end = {1'b0, e.x} + {1'b0, e.w};
        y_end = {1'b0, e.y} + {1'b0, e.h};
        return (cx >= e.x) && ({1'b0, cx} < x_end) &&
               (cy >= e.y) && ({1'b0, cy} < y_end);
    endfunction

    // Unpack the input transfer
    assign in_op       = cvl_pkg::opcode_t'(s_tuser);
    assign in_addr     = s_tdata[15:0];
    assign in_entry.x  = s_tdata[26:16];
    assign in_entry.y  = s_tdata[37:27];
    assign in_entry.w  = s_tdata[48:38];
    assign in_entry.h  = s_tdata[59:49];
    assign in_entry.solid = s_tdata[60];
    assign in_vis_bit  = s_tdata[61];
    assign in_ox       = s_tdata[73:62];
    assign in_oy       = s_tdata[85:74];
    assign in_tx       = s_tdata[97:86];
    assign in_ty       = s_tdata[109:98];

    assign s_tready  = (state_reg == S_IDLE) && clear_done;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Saturate the configured sizes
    assign grid_w_eff = (grid_w_reg > CW'(cvl_pkg::MAX_GRID)) ?
                        CW'(cvl_pkg::MAX_GRID) : grid_w_reg;
    assign grid_h_eff = (grid_h_reg > CW'(cvl_pkg::MAX_GRID)) ?
                        CW'(cvl_pkg::MAX_GRID) : grid_h_reg;
    assign n_eff = (region_count_reg > cvl_pkg::CNT_W'(cvl_pkg::MAX_REGIONS)) ?
                   cvl_pkg::CNT_W'(cvl_pkg::MAX_REGIONS) : region_count_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_w_reg       <= CW'(64);
            grid_h_reg       <= CW'(64);
            region_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cvl_pkg::cfg_index_t'(cfg_index))
                cvl_pkg::CFG_GRID_WIDTH:   grid_w_reg <= cfg_data;
                cvl_pkg::CFG_GRID_HEIGHT:  grid_h_reg <= cfg_data;
                cvl_pkg::CFG_REGION_COUNT: region_count_reg <= cfg_data[cvl_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Region table: one write port, one registered read port
    assign reg_we = s_accept && (in_op == cvl_pkg::OP_REGION_WRITE) &&
                    (in_addr < 16'(cvl_pkg::MAX_REGIONS));
    assign reg_rd_addr = (state_reg == S_SCAN) ?
                         cvl_pkg::REG_AW'(cmp_idx_reg + 1'b1) : '0;

    always_ff @(posedge aclk) begin
        if (reg_we) begin
            region_mem[in_addr[cvl_pkg::REG_AW-1:0]] <= in_entry;
        end
        region_rd_reg <= region_mem[reg_rd_addr];
    end

    // Scan control: data on the read port belongs to entry cmp_idx_reg
    assign obs_done = obs_found_reg || !obs_in_reg;
    assign tgt_done = tgt_found_reg || !tgt_in_reg;
    assign scan_end = (cmp_idx_reg >= cvl_pkg::REG_CW'(n_eff)) || (obs_done && tgt_done);
    assign obs_hit  = !obs_done && cell_in_region(obs_x_reg, obs_y_reg, region_rd_reg);
    assign tgt_hit  = !tgt_done && cell_in_region(tgt_x_reg, tgt_y_reg, region_rd_reg);
    assign flat     = cvl_pkg::FLAT_W'(prod_reg) + cvl_pkg::FLAT_W'(tgt_idx_reg);

    // State sequence
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_accept && (in_op == cvl_pkg::OP_QUERY)) state_next = S_SCAN;
            S_SCAN:  if (scan_end) state_next = S_MUL;
            S_MUL:   state_next = S_VREAD;
            S_VREAD: state_next = S_VRES;
            S_VRES:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Query datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                obs_x_reg     <= in_ox[CW-1:0];
                obs_y_reg     <= in_oy[CW-1:0];
                tgt_x_reg     <= in_tx[CW-1:0];
                tgt_y_reg     <= in_ty[CW-1:0];
                obs_in_reg    <= cell_in_grid(in_ox, grid_w_eff) &&
                                 cell_in_grid(in_oy, grid_h_eff);
                tgt_in_reg    <= cell_in_grid(in_tx, grid_w_eff) &&
                                 cell_in_grid(in_ty, grid_h_eff);
                obs_found_reg <= 1'b0;
                tgt_found_reg <= 1'b0;
                obs_solid_reg <= 1'b0;
                tgt_solid_reg <= 1'b0;
                obs_idx_reg   <= '0;
                tgt_idx_reg   <= '0;
                cmp_idx_reg   <= '0;
            end
            S_SCAN: begin
                if (!scan_end) begin
                    if (obs_hit) begin
                        obs_found_reg <= 1'b1;
                        obs_idx_reg   <= cmp_idx_reg[cvl_pkg::REG_AW-1:0];
                        obs_solid_reg <= region_rd_reg.solid;
                    end
                    if (tgt_hit) begin
                        tgt_found_reg <= 1'b1;
                        tgt_idx_reg   <= cmp_idx_reg[cvl_pkg::REG_AW-1:0];
                        tgt_solid_reg <= region_rd_reg.solid;
                    end
                    cmp_idx_reg <= cmp_idx_reg + 1'b1;
                end
            end
            S_MUL: begin
                prod_reg <= cvl_pkg::PROD_W'(obs_idx_reg) * cvl_pkg::PROD_W'(n_eff);
            end
            S_VREAD: begin
                vis_addr_reg <= flat[cvl_pkg::VIS_AW-1:0];
                vis_ok_reg   <= obs_found_reg && tgt_found_reg &&
                                !obs_solid_reg && !tgt_solid_reg &&
                                (flat < cvl_pkg::FLAT_W'(cvl_pkg::VIS_DEPTH));
            end
            default: ;
        endcase
    end

    // Visibility store access: bit writes while idle, matrix read at the end
    assign vis_cmd.wr_en   = s_accept && (in_op == cvl_pkg::OP_VIS_WRITE);
    assign vis_cmd.wr_addr = in_addr[cvl_pkg::VIS_AW-1:0];
    assign vis_cmd.wr_data = in_vis_bit;
    assign vis_cmd.rd_addr = (state_reg == S_VREAD) ?
                             flat[cvl_pkg::VIS_AW-1:0] : vis_addr_reg;

    cvl_vis_store u_vis_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (vis_cmd),
        .rd_data    (vis_rd_data),
        .clear_done (clear_done)
    );

    // Output register: load once the previous result has gone
    assign out_load = (state_reg == S_VRES) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {5'b0, tgt_idx_reg, obs_idx_reg, tgt_found_reg,
                            obs_found_reg, vis_ok_reg && vis_rd_data};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_no_item_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !clear_done |-> !s_tready)
        else $error("input taken during visibility clearing pass");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !(m_tvalid_reg && !m_tready))
        else $error("result register loaded while still occupied");

    a_visible_needs_regions: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (!m_tdata_reg[0] || (m_tdata_reg[1] && m_tdata_reg[2])))
        else $error("visible result without both regions found");

endmodule

`default_nettype wire
